// File: design/alarm_notification_sequencer_top_defines.svh
// Assertion macros for the alarm notification sequencer RTL
`ifndef ALARM_NOTIFICATION_SEQUENCER_TOP_DEFINES_SVH
`define ALARM_NOTIFICATION_SEQUENCER_TOP_DEFINES_SVH

// clocked check, disabled while reset is asserted
`define ANS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked check, active during reset too
`define ANS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: design/ans_pkg.sv
// Types and constants for the alarm notification sequencer
package ans_pkg;

  localparam int unsigned ANS_QUEUE_DEPTH = 2;
  localparam int unsigned ANS_INTERVAL_W  = 27;
  localparam logic [ANS_INTERVAL_W-1:0] ANS_MS_PER_MINUTE = ANS_INTERVAL_W'(60000);
  localparam logic [15:0] ANS_COUNT_MAX = 16'hFFFF;
  localparam logic [2:0]  ANS_TYPE_NONE = 3'd0;

  typedef enum logic [1:0] {
    KIND_STARTED = 2'd0,
    KIND_REPEAT  = 2'd1,
    KIND_CLEARED = 2'd2
  } ans_kind_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        alarm_active;
    logic [2:0]  alarm_type;
  } ans_in_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [2:0]  event_type;
    logic [15:0] notice_count;
    logic        last_of_run;
  } ans_out_t;

  typedef struct packed {
    ans_kind_t   kind;
    logic [2:0]  evt_type;
    logic [15:0] count;
  } ans_event_t;

  // one queued transaction: one or two events from a single update
  typedef struct packed {
    logic       two;
    ans_event_t ev0;
    ans_event_t ev1;
  } ans_entry_t;

  typedef struct packed {
    logic       valid;
    ans_entry_t entry;
  } ans_head_t;

endpackage

// File: design/ans_front.sv
// Front end: accepts updates, tracks alarm state, classifies into events
module ans_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          run,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ans_pkg::ans_in_t              in_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [10:0]                   cfg_data,
  input  logic                          q_full,
  output logic                          push,
  output ans_pkg::ans_entry_t           push_entry
);
  import ans_pkg::*;

  logic                      was_active_r, was_active_nxt;
  logic [2:0]                prior_type_r, prior_type_nxt;
  logic [31:0]               last_time_r, last_time_nxt;
  logic [15:0]               count_r, count_nxt;
  logic [ANS_INTERVAL_W-1:0] interval_r;

  logic        accept;
  logic        has_event;
  logic [2:0]  cur_type;
  logic [31:0] elapsed;
  logic        due;
  logic [15:0] count_inc;

  assign in_ready  = run & ~q_full;
  assign cfg_ready = run;
  assign accept    = in_valid & in_ready;

  assign cur_type  = in_data.alarm_active ? in_data.alarm_type : ANS_TYPE_NONE;
  assign elapsed   = in_data.now_ms - last_time_r;
  assign due       = elapsed >= {{(32-ANS_INTERVAL_W){1'b0}}, interval_r};
  assign count_inc = (count_r < ANS_COUNT_MAX) ? count_r + 16'd1 : count_r;

  always_comb begin
    has_event        = 1'b0;
    push_entry       = '0;
    push_entry.ev0   = '{kind: KIND_STARTED, evt_type: cur_type, count: 16'd1};
    push_entry.ev1   = '{kind: KIND_STARTED, evt_type: cur_type, count: 16'd1};
    count_nxt        = count_r;
    last_time_nxt    = last_time_r;
    priority if (in_data.alarm_active && !was_active_r) begin
      has_event     = 1'b1;
      count_nxt     = 16'd1;
      last_time_nxt = in_data.now_ms;
    end else if (in_data.alarm_active && cur_type != prior_type_r) begin
      has_event      = 1'b1;
      push_entry.two = 1'b1;
      push_entry.ev0 = '{kind: KIND_CLEARED, evt_type: prior_type_r, count: count_r};
      count_nxt      = 16'd1;
      last_time_nxt  = in_data.now_ms;
    end else if (in_data.alarm_active) begin
      if (due) begin
        has_event      = 1'b1;
        push_entry.ev0 = '{kind: KIND_REPEAT, evt_type: cur_type, count: count_inc};
        count_nxt      = count_inc;
        last_time_nxt  = in_data.now_ms;
      end
    end else if (was_active_r) begin
      has_event      = 1'b1;
      push_entry.ev0 = '{kind: KIND_CLEARED, evt_type: prior_type_r, count: count_r};
      count_nxt      = 16'd0;
      last_time_nxt  = 32'd0;
    end
    was_active_nxt = in_data.alarm_active;
    prior_type_nxt = cur_type;
  end

  assign push = accept & has_event;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_active_r <= 1'b0;
      prior_type_r <= ANS_TYPE_NONE;
      last_time_r  <= 32'd0;
      count_r      <= 16'd0;
      interval_r   <= '0;
    end else begin
      if (accept) begin
        was_active_r <= was_active_nxt;
        prior_type_r <= prior_type_nxt;
        last_time_r  <= last_time_nxt;
        count_r      <= count_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        interval_r <= ANS_INTERVAL_W'(cfg_data) * ANS_MS_PER_MINUTE;
      end
    end
  end

endmodule

// File: design/ans_queue.sv
// Small FIFO of classified transactions between front and back ends
`include "alarm_notification_sequencer_top_defines.svh"
module ans_queue #(
  parameter int unsigned DEPTH = ans_pkg::ANS_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ans_pkg::ans_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output ans_pkg::ans_head_t  head
);
  import ans_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ans_entry_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full       = count_r == CNT_W'(DEPTH);
  assign head.valid = count_r != '0;
  assign head.entry = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  `ANS_ASSERT(a_no_push_full, !(push && full), "queue push while full")
  `ANS_ASSERT(a_no_pop_empty, !(pop && !head.valid), "queue pop while empty")
  `ANS_ASSERT(a_count_up, (push && !pop) |=> (count_r == $past(count_r) + 1'b1), "count slip")
  `ANS_ASSERT(a_count_bound, count_r <= CNT_W'(DEPTH), "queue count overflow")
  `ANS_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (count_r == '0), "queue not empty after reset")

endmodule

// File: design/ans_back.sv
// Back end: drains queued transactions into the registered result port
module ans_back (
  input  logic               clk,
  input  logic               rst_n,
  input  ans_pkg::ans_head_t head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output ans_pkg::ans_out_t  out_data
);
  import ans_pkg::*;

  logic       out_valid_r;
  ans_out_t   out_data_r;
  logic       phase_r;
  logic       load;
  logic       last;
  ans_event_t ev;

  assign load = head.valid & (~out_valid_r | out_ready);
  assign ev   = phase_r ? head.entry.ev1 : head.entry.ev0;
  assign last = ~head.entry.two | phase_r;
  assign pop  = load & last;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r.event_kind   <= ev.kind;
      out_data_r.event_type   <= ev.evt_type;
      out_data_r.notice_count <= ev.count;
      out_data_r.last_of_run  <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        phase_r     <= ~last;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// File: design/alarm_notification_sequencer_top.sv
// Top level of the alarm notification sequencer
//
//  channel | direction | payload          | handshake
//  in_     | input     | ans_in_t update  | in_valid / in_ready
//  out_    | output    | ans_out_t event  | out_valid / out_ready
//  cfg_    | input     | repeat_minutes   | cfg_valid / cfg_ready
//
// An update producing at most one event is taken every cycle while the transaction
// queue has room; a type change yields two events and occupies the back end for both.
// Results pass through the transaction queue and then the registered output port.
// Reset: synchronous, active low; all ports ready in the cycle after release.
// Stalls on out_ready back up through the transaction queue to in_ready.
module alarm_notification_sequencer_top #(
  parameter int unsigned QUEUE_DEPTH = ans_pkg::ANS_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ans_pkg::ans_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ans_pkg::ans_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [10:0]       cfg_data
);
  import ans_pkg::*;

  logic       run_r;
  logic       push;
  logic       pop;
  logic       q_full;
  ans_entry_t push_entry;
  ans_head_t  head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else begin
      run_r <= 1'b1;
    end
  end

  ans_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .run        (run_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  ans_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head       (head)
  );

  ans_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: bench/alarm_notification_sequencer_top_tb.sv
// Self-checking bench: alarm notice sequencing and repeat timing
module alarm_notification_sequencer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ans_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 4_000_000;
  localparam logic [31:0] MS_PER_MIN = 32'd60000;
  localparam logic [15:0] COUNT_TOP = 16'hFFFF;
  localparam logic [2:0]  TYPE_NONE = 3'd0;
  localparam int RAND_PHASES = 5;
  localparam int PHASE_ITEMS = 105;
  localparam int USE_MODEL = -1;
  localparam ans_out_t NO_NOTICE = '0;

  typedef struct {
    logic        is_cfg;
    logic [10:0] cfg_val;
    ans_in_t     upd;
    int          lit_n;
    ans_out_t    lit0;
    ans_out_t    lit1;
  } stim_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  ans_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  ans_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [10:0] cfg_data = '0;

  // predictor state
  logic        seen_active = 1'b0;
  logic [2:0]  seen_type = TYPE_NONE;
  logic [31:0] last_notice_ms = '0;
  logic [15:0] notice_cnt = '0;
  logic [10:0] repeat_min = '0;

  ans_out_t    due_notices[$];
  stim_row_t   directed_rows[$];
  int          err_count = 0;
  int          burst_left = 0;
  int unsigned cycle_count = 0;

  logic [1:0]  stall_mode = '0;
  int          stall_left = 0;
  logic [7:0]  stall_mask = 8'hFF;
  logic [2:0]  stall_phase = '0;

  alarm_notification_sequencer_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic ans_out_t notice(ans_kind_t k, logic [2:0] t, logic [15:0] c, logic last);
    ans_out_t r;
    r.event_kind   = k;
    r.event_type   = t;
    r.notice_count = c;
    r.last_of_run  = last;
    return r;
  endfunction

  function automatic int predict_notices(input ans_in_t upd, output ans_out_t ev0,
                                         output ans_out_t ev1);
    logic [2:0]  cur_type;
    logic [31:0] interval;
    logic [31:0] elapsed;
    int          n;
    cur_type = upd.alarm_active ? upd.alarm_type : TYPE_NONE;
    n = 0;
    ev0 = NO_NOTICE;
    ev1 = NO_NOTICE;
    if (upd.alarm_active && !seen_active) begin
      notice_cnt = 16'd1;
      last_notice_ms = upd.now_ms;
      ev0 = notice(KIND_STARTED, cur_type, notice_cnt, 1'b1);
      n = 1;
    end else if (upd.alarm_active && cur_type != seen_type) begin
      ev0 = notice(KIND_CLEARED, seen_type, notice_cnt, 1'b0);
      notice_cnt = 16'd1;
      last_notice_ms = upd.now_ms;
      ev1 = notice(KIND_STARTED, cur_type, notice_cnt, 1'b1);
      n = 2;
    end else if (upd.alarm_active) begin
      interval = 32'(repeat_min) * MS_PER_MIN;
      elapsed = upd.now_ms - last_notice_ms;
      if (elapsed >= interval) begin
        if (notice_cnt != COUNT_TOP) notice_cnt = notice_cnt + 16'd1;
        last_notice_ms = upd.now_ms;
        ev0 = notice(KIND_REPEAT, cur_type, notice_cnt, 1'b1);
        n = 1;
      end
    end else if (seen_active) begin
      ev0 = notice(KIND_CLEARED, seen_type, notice_cnt, 1'b1);
      notice_cnt = '0;
      last_notice_ms = '0;
      n = 1;
    end
    seen_active = upd.alarm_active;
    seen_type = cur_type;
    return n;
  endfunction

  function automatic void add_upd(logic [31:0] t_ms, logic act, logic [2:0] ty, int n,
                                  ans_out_t e0, ans_out_t e1);
    stim_row_t r;
    r.is_cfg = 1'b0;
    r.cfg_val = '0;
    r.upd.now_ms = t_ms;
    r.upd.alarm_active = act;
    r.upd.alarm_type = ty;
    r.lit_n = n;
    r.lit0 = e0;
    r.lit1 = e1;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_cfg(logic [10:0] v);
    stim_row_t r;
    r = '{is_cfg: 1'b1, cfg_val: v, upd: '0, lit_n: 0, lit0: NO_NOTICE, lit1: NO_NOTICE};
    directed_rows.push_back(r);
  endfunction

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want)
      flag_error($sformatf("%s mismatch: got %0d, expected %0d", name, got, want));
  endtask

  task automatic send_update(input ans_in_t upd, input int lit_n, input ans_out_t lit0,
                             input ans_out_t lit1);
    ans_out_t p0;
    ans_out_t p1;
    int       n;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= upd;
    do @(posedge clk); while (!in_ready);
    n = predict_notices(upd, p0, p1);
    if (lit_n != USE_MODEL) begin
      n = lit_n;
      p0 = lit0;
      p1 = lit1;
    end
    if (n > 0) due_notices.push_back(p0);
    if (n > 1) due_notices.push_back(p1);
  endtask

  task automatic drain_notices();
    in_valid <= 1'b0;
    while (due_notices.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_interval(input logic [10:0] v);
    drain_notices();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    repeat_min = v;
    cfg_valid <= 1'b0;
  endtask

  // result side: checker and stall pattern
  always @(posedge clk) begin : recv
    ans_out_t want;
    logic     nxt;
    if (rst_n && out_valid && out_ready) begin
      if (due_notices.size() == 0) begin
        flag_error($sformatf("unexpected notice kind=%0d type=%0d count=%0d last=%0b",
                             out_data.event_kind, out_data.event_type,
                             out_data.notice_count, out_data.last_of_run));
      end else begin
        want = due_notices.pop_front();
        compare_field("event_kind", 16'(out_data.event_kind), 16'(want.event_kind));
        compare_field("event_type", 16'(out_data.event_type), 16'(want.event_type));
        compare_field("notice_count", out_data.notice_count, want.notice_count);
        compare_field("last_of_run", 16'(out_data.last_of_run), 16'(want.last_of_run));
      end
    end
    if (stall_left == 0) begin
      stall_mode <= 2'($urandom_range(0, 3));
      stall_left <= $urandom_range(16, 80);
      stall_mask <= 8'($urandom) | 8'h01;
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_phase <= stall_phase + 3'd1;
    case (stall_mode)
      2'd0: nxt = 1'b1;
      2'd1: nxt = 1'($urandom_range(0, 1));
      2'd2: nxt = stall_mask[stall_phase];
      default: nxt = ($urandom_range(0, 3) == 0);
    endcase
    out_ready <= nxt;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d notices outstanding", cycle_count,
               due_notices.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    ans_in_t     upd;
    logic [31:0] step;
    logic [31:0] interval;
    logic [31:0] wall_ms;
    int          pick;
    int          choice;

    add_upd(32'd0, 1'b0, 3'd0, 0, NO_NOTICE, NO_NOTICE);
    add_upd(32'd10, 1'b0, 3'd5, 0, NO_NOTICE, NO_NOTICE);
    add_upd(32'd100, 1'b1, 3'd1, 1, notice(KIND_STARTED, 3'd1, 16'd1, 1'b1), NO_NOTICE);
    add_upd(32'd100, 1'b1, 3'd1, USE_MODEL, NO_NOTICE, NO_NOTICE);
    add_upd(32'd200, 1'b1, 3'd2, USE_MODEL, NO_NOTICE, NO_NOTICE);
    add_upd(32'hFFFF_FFFF, 1'b1, 3'd2, 1, notice(KIND_REPEAT, 3'd2, 16'd2, 1'b1), NO_NOTICE);
    add_upd(32'd5, 1'b1, 3'd2, USE_MODEL, NO_NOTICE, NO_NOTICE);
    add_upd(32'd6, 1'b0, 3'd7, USE_MODEL, NO_NOTICE, NO_NOTICE);
    add_upd(32'hFFFF_FFFF, 1'b1, 3'd7, 1, notice(KIND_STARTED, 3'd7, 16'd1, 1'b1), NO_NOTICE);
    add_upd(32'hFFFF_FFFF, 1'b1, 3'd6, 2, notice(KIND_CLEARED, 3'd7, 16'd1, 1'b0),
            notice(KIND_STARTED, 3'd6, 16'd1, 1'b1));
    add_upd(32'd0, 1'b1, 3'd0, USE_MODEL, NO_NOTICE, NO_NOTICE);
    add_upd(32'd1, 1'b1, 3'd0, USE_MODEL, NO_NOTICE, NO_NOTICE);
    add_upd(32'd2, 1'b0, 3'd3, USE_MODEL, NO_NOTICE, NO_NOTICE);
    add_upd(32'd3, 1'b1, 3'd3, USE_MODEL, NO_NOTICE, NO_NOTICE);
    add_upd(32'd4, 1'b1, 3'd4, USE_MODEL, NO_NOTICE, NO_NOTICE);
    add_upd(32'd5, 1'b0, 3'd0, USE_MODEL, NO_NOTICE, NO_NOTICE);
    add_upd(32'd6, 1'b0, 3'd6, USE_MODEL, NO_NOTICE, NO_NOTICE);
    add_upd(32'd7, 1'b1, 3'd5, USE_MODEL, NO_NOTICE, NO_NOTICE);
    add_cfg(11'd1);
    add_upd(32'd1000, 1'b1, 3'd5, USE_MODEL, NO_NOTICE, NO_NOTICE);
    add_upd(32'd60006, 1'b1, 3'd5, USE_MODEL, NO_NOTICE, NO_NOTICE);
    add_upd(32'd60007, 1'b1, 3'd5, USE_MODEL, NO_NOTICE, NO_NOTICE);
    add_cfg(11'd2047);
    add_upd(32'd122880006, 1'b1, 3'd5, 0, NO_NOTICE, NO_NOTICE);
    add_upd(32'd122880007, 1'b1, 3'd5, 1, notice(KIND_REPEAT, 3'd5, 16'd3, 1'b1), NO_NOTICE);
    add_cfg(11'd1440);
    add_upd(32'd122880008, 1'b0, 3'd5, USE_MODEL, NO_NOTICE, NO_NOTICE);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg)
        write_interval(directed_rows[i].cfg_val);
      else
        send_update(directed_rows[i].upd, directed_rows[i].lit_n, directed_rows[i].lit0,
                    directed_rows[i].lit1);
    end
    drain_notices();

    wall_ms = $urandom;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: pick = 1;
        1: pick = 0;
        2: pick = 2047;
        3: pick = $urandom_range(2, 1440);
        default: pick = $urandom_range(0, 2047);
      endcase
      write_interval(11'(pick));
      interval = 32'(repeat_min) * MS_PER_MIN;
      repeat (PHASE_ITEMS) begin
        case ($urandom_range(0, 3))
          0: step = '0;
          1: step = $urandom_range(0, 3000);
          2: step = interval + $urandom_range(0, 2000) - 32'd1000;
          default: step = $urandom;
        endcase
        wall_ms = wall_ms + step;
        upd.now_ms = wall_ms;
        upd.alarm_active = seen_active;
        upd.alarm_type = seen_active ? seen_type : 3'($urandom_range(0, 7));
        choice = $urandom_range(0, 99);
        if (choice < 15) begin
          upd.alarm_active = ~seen_active;
          upd.alarm_type = 3'($urandom_range(0, 7));
        end else if (choice < 25) begin
          upd.alarm_active = 1'b1;
          upd.alarm_type = seen_type ^ 3'($urandom_range(1, 7));
        end else if (choice < 33) begin
          upd = {$urandom, 4'($urandom)};
        end else if (choice < 45 && seen_active) begin
          // just below, at, or just past the repeat threshold
          upd.now_ms = last_notice_ms + interval + $urandom_range(0, 2) - 32'd1;
        end
        wall_ms = upd.now_ms;
        if ($urandom_range(0, 99) == 0) drain_notices();
        send_update(upd, USE_MODEL, NO_NOTICE, NO_NOTICE);
      end
    end

    in_valid <= 1'b0;
    while (due_notices.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (due_notices.size() != 0)
      flag_error($sformatf("%0d notices never arrived", due_notices.size()));
    if (err_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
